// File: design/stcm_pkg.sv
// ----------------------------------------------------------------------------
// stcm_pkg
// Shared types, constants and helpers of the stick-to-touch cursor mapper.
// ----------------------------------------------------------------------------
package stcm_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 192;
   localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int CUR_W = (COL_W > ROW_W) ? COL_W : ROW_W;

   // register widths, limits and reset values
   localparam int DZ_W    = 15;
   localparam int SPEED_W = 8;
   localparam int CSR_W   = 15;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_SPEED = 1'd1;
   localparam logic [DZ_W-1:0]    DZ_MAX      = 15'd32766;
   localparam logic [DZ_W-1:0]    DZ_RESET    = 15'd8000;
   localparam logic [DZ_W-1:0]    STICK_FULL  = 15'd32767;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd6;

   // field widths
   localparam int KEY_W  = 12;
   localparam int AXIS_W = 16;
   localparam int TRIG_W = 8;
   localparam int TOUCH_W = 8;
   localparam logic [TRIG_W-1:0] TRIG_THRESHOLD = 8'd32;

   // divider: the quotient never exceeds 2*(255-1), so nine bits suffice
   localparam int Q_W    = 9;
   localparam int CNT_W  = $clog2(Q_W);
   localparam int PROD_W = DZ_W + Q_W - 1;          // range shifted by Q_W-1
   localparam int STEP_W = Q_W + 1;
   localparam int POS_W  = ((CUR_W > STEP_W) ? CUR_W : STEP_W) + 2;

   // short queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0]  pad_buttons;
      logic signed [AXIS_W-1:0] stick_x;
      logic signed [AXIS_W-1:0] stick_y;
      logic [TRIG_W-1:0] trigger_level;
   } req_data_type;

   typedef struct packed {
      logic [KEY_W-1:0]   handheld_buttons;
      logic [TOUCH_W-1:0] touch_x;
      logic [TOUCH_W-1:0] touch_y;
      logic               touch_pressed;
   } rsp_data_type;

   // one axis after dead-zone classification
   typedef struct packed {
      logic              active;
      logic              negative;
      logic [AXIS_W-1:0] excess;
   } axis_type;

   // queue entry: one classified snapshot
   typedef struct packed {
      logic [KEY_W-1:0] keys;
      logic             pressed;
      axis_type         x_axis;
      axis_type         y_axis;
   } entry_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // move pad bits into handheld key order
   function automatic logic [KEY_W-1:0] repack_keys(input logic [KEY_W-1:0] pad);
      logic [KEY_W-1:0] k;
      k = '0;
      k[0]  = pad[0];
      k[1]  = pad[1];
      k[10] = pad[2];
      k[11] = pad[3];
      k[6]  = pad[4];
      k[7]  = pad[5];
      k[5]  = pad[6];
      k[4]  = pad[7];
      k[9]  = pad[8];
      k[8]  = pad[9];
      k[3]  = pad[10];
      k[2]  = pad[11];
      return k;
   endfunction

endpackage

// File: design/stcm_front.sv
// ----------------------------------------------------------------------------
// stcm_front
// Accepts snapshots, repacks buttons and classifies each stick axis against
// the dead zone before handing the transaction to the queue.
// ----------------------------------------------------------------------------
module stcm_front (
   input  logic                        req_valid,
   input  stcm_pkg::req_data_type      req_data,
   output logic                        req_stall,
   input  logic [stcm_pkg::DZ_W-1:0]   deadband,
   input  stcm_pkg::queue_status_type  queue_status,
   output logic                        push,
   output stcm_pkg::entry_type         push_entry
);
   import stcm_pkg::*;

   // stall while the queue has no room
   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   function automatic axis_type classify(input logic signed [AXIS_W-1:0] v,
                                         input logic [DZ_W-1:0] dz);
      axis_type         a;
      logic [AXIS_W-1:0] mag;
      mag        = v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
      a.negative = v[AXIS_W-1];
      a.active   = mag > AXIS_W'(dz);
      a.excess   = mag - AXIS_W'(dz);
      return a;
   endfunction

   // classify the snapshot
   always_comb begin
      push_entry.keys    = repack_keys(req_data.pad_buttons);
      push_entry.pressed = req_data.trigger_level > TRIG_THRESHOLD;
      push_entry.x_axis  = classify(req_data.stick_x, deadband);
      push_entry.y_axis  = classify(req_data.stick_y, deadband);
   end

endmodule

// File: design/stcm_queue.sv
// ----------------------------------------------------------------------------
// stcm_queue
// Short first-in first-out queue of classified snapshots between the
// front and the back.
// ----------------------------------------------------------------------------
module stcm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  stcm_pkg::entry_type         push_entry,
   input  logic                        pop,
   output stcm_pkg::entry_type         pop_entry,
   output stcm_pkg::queue_status_type  queue_status
);
   import stcm_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign queue_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign queue_status.empty = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/stcm_back.sv
// ----------------------------------------------------------------------------
// stcm_back
// Scales each active axis through one shared restoring divider, moves and
// clamps the cursor, and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
module stcm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [stcm_pkg::DZ_W-1:0]     deadband,
   input  logic [stcm_pkg::SPEED_W-1:0]  cursor_speed,
   input  stcm_pkg::queue_status_type    queue_status,
   input  stcm_pkg::entry_type           pop_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   output stcm_pkg::rsp_data_type        rsp_data,
   input  logic                          rsp_stall
);
   import stcm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   localparam logic [POS_W-1:0] COL_TOP = POS_W'(SCREEN_WIDTH - 1);
   localparam logic [POS_W-1:0] ROW_TOP = POS_W'(SCREEN_HEIGHT - 1);

   logic [1:0]        state_ff, state_in;
   logic              axis_ff, axis_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         entry_ff, entry_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [CUR_W-1:0]  col_ff, col_in;
   logic [CUR_W-1:0]  row_ff, row_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   axis_type                 cur_axis;
   logic [DZ_W-1:0]          range;
   logic [AXIS_W+SPEED_W-1:0] product;
   logic [STEP_W-1:0]        step;
   logic                     move_up;
   logic signed [POS_W-1:0]  base;
   logic signed [POS_W-1:0]  moved;
   logic [POS_W-1:0]         top;
   logic [CUR_W-1:0]         clamped;

   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // datapath for the axis being worked
   always_comb begin
      cur_axis = axis_ff ? entry_ff.y_axis : entry_ff.x_axis;
      range    = STICK_FULL - deadband;
      product  = cur_axis.excess * (cursor_speed - SPEED_W'(1));
      step     = cur_axis.active ? (STEP_W'(quo_ff) + STEP_W'(1)) : '0;
      // X adds the step, Y subtracts it: the sign decides the direction
      move_up  = cur_axis.negative ^ axis_ff;
      base     = axis_ff ? POS_W'(row_ff) : POS_W'(col_ff);
      top      = axis_ff ? ROW_TOP : COL_TOP;
      moved    = move_up ? (base - POS_W'(step)) : (base + POS_W'(step));
      priority if (moved < 0) begin
         clamped = '0;
      end else if (moved > $signed(top)) begin
         clamped = CUR_W'(top);
      end else begin
         clamped = CUR_W'(moved);
      end
   end

   // sequence: load, multiply, divide, apply for X then Y
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      entry_in     = entry_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               entry_in = pop_entry;
               axis_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in   = PROD_W'(product);
            div_in   = {range, (Q_W-1)'(0)};
            quo_in   = '0;
            cnt_in   = CNT_W'(Q_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
               quo_in = {quo_ff[Q_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[Q_W-2:0], 1'b0};
            end
            div_in = div_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_APPLY: begin
            if (!axis_ff) begin
               col_in   = clamped;
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               row_in       = clamped;
               rsp_data_in.handheld_buttons = entry_ff.keys;
               rsp_data_in.touch_x          = TOUCH_W'(col_ff);
               rsp_data_in.touch_y          = TOUCH_W'(clamped);
               rsp_data_in.touch_pressed    = entry_ff.pressed;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= CUR_W'(SCREEN_WIDTH / 2);
         row_ff       <= CUR_W'(SCREEN_HEIGHT / 2);
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // hold working values and the result
   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/stick_to_touch_cursor_mapper_core.sv
// ----------------------------------------------------------------------------
// stick_to_touch_cursor_mapper_core
// Maps a controller snapshot to handheld keys, a touch cursor and touch press.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction is popped from the queue, then each axis
// goes through a multiply step, nine divider steps and an apply step, and the
// finished transaction is held in the result register.
// The back pops the next entry only once it is idle again and the result
// register has drained, so a result stall holds it back.
// Reset: synchronous; dead zone 8000, speed 6, cursor at screen center.
module stick_to_touch_cursor_mapper_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  stcm_pkg::req_data_type          req_data,
   output logic                            req_stall,
   output logic                            rsp_valid,
   output stcm_pkg::rsp_data_type          rsp_data,
   input  logic                            rsp_stall,
   input  logic                            csr_we,
   input  logic [stcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stcm_pkg::CSR_W-1:0]      csr_wdata
);
   import stcm_pkg::*;

   logic [DZ_W-1:0]    deadband_ff, deadband_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [SPEED_W-1:0] speed_wr;

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        pop_entry;
   queue_status_type queue_status;

   // write configuration registers: mask, then saturate to legal values
   always_comb begin
      deadband_in = deadband_ff;
      speed_in    = speed_ff;
      speed_wr    = csr_wdata[SPEED_W-1:0];
      if (csr_we) begin
         unique case (csr_index)
            REG_DEADBAND: begin
               deadband_in = (csr_wdata[DZ_W-1:0] > DZ_MAX) ? DZ_MAX : csr_wdata[DZ_W-1:0];
            end
            REG_CURSOR_SPEED: begin
               speed_in = (speed_wr == '0) ? SPEED_W'(1) : speed_wr;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DZ_RESET;
         speed_ff    <= SPEED_RESET;
      end else begin
         deadband_ff <= deadband_in;
         speed_ff    <= speed_in;
      end
   end

   stcm_front u_front (
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .deadband     (deadband_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   stcm_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .pop_entry    (pop_entry),
      .queue_status (queue_status)
   );

   stcm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .deadband     (deadband_ff),
      .cursor_speed (speed_ff),
      .queue_status (queue_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule

// File: bench/tb_stick_to_touch_cursor_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_stick_to_touch_cursor_mapper_core
// Drives controller snapshots into the cursor mapper under several dead zone
// and speed settings. Every frame is checked field by field against an
// in-bench model of the key repacking, the dead zone, the cursor and the press.
// ----------------------------------------------------------------------------
module tb_stick_to_touch_cursor_mapper_core;
   import stcm_pkg::*;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_data_type         req_data  = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   rsp_data_type         rsp_data;
   logic                 rsp_stall = 1'b0;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_DEADBAND;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // model copy of registers and cursor
   int deadband_now;
   int speed_now;
   int col_now;
   int row_now;

   // frames predicted but not yet seen on the result side
   rsp_data_type frames_in_flight[$];

   int  mismatch_count  = 0;
   int  frames_checked  = 0;
   int  snapshots_sent  = 0;
   int  settings_used   = 0;
   int  stall_left      = 0;
   bit  req_held        = 1'b0;
   bit  gaps_on         = 1'b0;
   bit  stalls_on       = 1'b0;

   stick_to_touch_cursor_mapper_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // handheld bit that each pad bit lands on
   function automatic int key_slot(input int pad_bit);
      case (pad_bit)
         0:       return 0;
         1:       return 1;
         2:       return 10;
         3:       return 11;
         4:       return 6;
         5:       return 7;
         6:       return 5;
         7:       return 4;
         8:       return 9;
         9:       return 8;
         10:      return 3;
         default: return 2;
      endcase
   endfunction

   // signed cursor step of one stick axis
   function automatic int axis_step(input logic signed [AXIS_W-1:0] v);
      int mag;
      int step;
      mag = (v < 0) ? -int'(v) : int'(v);
      if (mag <= deadband_now) return 0;
      step = 1 + ((mag - deadband_now) * (speed_now - 1)) / (int'(STICK_FULL) - deadband_now);
      return (v < 0) ? -step : step;
   endfunction

   function automatic int clamp_pos(input int v, input int top);
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
   endfunction

   // advance the model cursor by one snapshot and build the frame it yields
   function automatic rsp_data_type map_snapshot(input req_data_type s);
      rsp_data_type r;
      int           b;
      r = '0;
      for (b = 0; b < KEY_W; b++) begin
         if (s.pad_buttons[b]) r.handheld_buttons[key_slot(b)] = 1'b1;
      end
      col_now = clamp_pos(col_now + axis_step(s.stick_x), SCREEN_WIDTH - 1);
      row_now = clamp_pos(row_now - axis_step(s.stick_y), SCREEN_HEIGHT - 1);
      r.touch_x       = col_now[TOUCH_W-1:0];
      r.touch_y       = row_now[TOUCH_W-1:0];
      r.touch_pressed = (s.trigger_level > TRIG_THRESHOLD);
      return r;
   endfunction

   // register write as the block sees it: mask, then saturate
   function automatic void load_register(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_W-1:0] value);
      int v;
      if (idx == REG_DEADBAND) begin
         v = int'(value[DZ_W-1:0]);
         deadband_now = (v > int'(DZ_MAX)) ? int'(DZ_MAX) : v;
      end else if (idx == REG_CURSOR_SPEED) begin
         v = int'(value[SPEED_W-1:0]);
         speed_now = (v < 1) ? 1 : v;
      end
   endfunction

   function automatic req_data_type make_snapshot(input int pad, input int x, input int y,
                                                  input int trig);
      req_data_type s;
      s.pad_buttons   = pad[KEY_W-1:0];
      s.stick_x       = x[AXIS_W-1:0];
      s.stick_y       = y[AXIS_W-1:0];
      s.trigger_level = trig[TRIG_W-1:0];
      return s;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // axis value biased toward the dead zone border and the rails
   function automatic int pick_axis();
      int v;
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         v = int'($urandom_range(0, 65535)) - 32768;
      end else if (r < 55) begin
         v = deadband_now + int'($urandom_range(0, 6)) - 3;
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       v = -32768;
            1:       v = -32767;
            2:       v = 32767;
            default: v = 0;
         endcase
      end else begin
         v = int'($urandom_range(0, 20000)) - 10000;
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // send one snapshot; returns at the accepting edge with valid still high
   task automatic send_snapshot(input req_data_type s);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         if (req_held) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      req_held = 1'b1;
      do @(posedge clock); while (req_stall);
      frames_in_flight.push_back(map_snapshot(s));
      snapshots_sent++;
   endtask

   // drop valid and hold until every predicted frame has come back
   task automatic wait_idle();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (frames_in_flight.size() != 0) @(posedge clock);
   endtask

   // write both registers on consecutive edges while the block is idle
   task automatic set_mapping(input int dz_raw, input int speed_raw);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= REG_DEADBAND;
      csr_wdata <= dz_raw[CSR_W-1:0];
      @(posedge clock);
      load_register(REG_DEADBAND, dz_raw[CSR_W-1:0]);
      csr_index <= REG_CURSOR_SPEED;
      csr_wdata <= speed_raw[CSR_W-1:0];
      @(posedge clock);
      load_register(REG_CURSOR_SPEED, speed_raw[CSR_W-1:0]);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // each pad button alone, cursor held still, trigger around the threshold
   task automatic test_key_repack();
      int b;
      int trig;
      for (b = 0; b < KEY_W; b++) begin
         case (b % 4)
            0:       trig = 0;
            1:       trig = int'(TRIG_THRESHOLD);
            2:       trig = int'(TRIG_THRESHOLD) + 1;
            default: trig = 255;
         endcase
         send_snapshot(make_snapshot(1 << b, 0, 0, trig));
      end
   endtask

   // reset settings: magnitudes on and just past the dead zone, both signs, and the rails
   task automatic test_deadband_edges();
      send_snapshot(make_snapshot(12'hFFF, 8000, 8001, 33));
      send_snapshot(make_snapshot(12'h000, 8001, -8000, 32));
      send_snapshot(make_snapshot(12'hA5A, -8001, -8001, 200));
      send_snapshot(make_snapshot(12'h5A5, 32767, -32768, 31));
   endtask

   // saturated dead zone, zero and masked speeds, screen clamps
   task automatic test_register_extremes();
      set_mapping(32767, 0);
      send_snapshot(make_snapshot(12'h001, -32768, -32768, 0));
      send_snapshot(make_snapshot(12'h002, 32767, 32767, 255));
      send_snapshot(make_snapshot(12'h004, 32766, -32767, 40));
      set_mapping(0, 15'h01FF);
      send_snapshot(make_snapshot(12'h008, 32767, 32767, 0));
      send_snapshot(make_snapshot(12'h010, -32768, -32768, 100));
      send_snapshot(make_snapshot(12'h020, 1, -1, 33));
      set_mapping(int'(DZ_MAX), 255);
      send_snapshot(make_snapshot(12'h040, -32768, 32767, 1));
      send_snapshot(make_snapshot(12'h080, 32767, -32768, 254));
      set_mapping(1234, 15'h7F00);
      send_snapshot(make_snapshot(12'h100, 20000, -20000, 64));
   endtask

   // random snapshots over several settings and idling patterns
   task automatic test_random_frames();
      int phase;
      int n;
      int pad;
      int trig;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       set_mapping(int'(DZ_RESET), int'(SPEED_RESET));
            1:       set_mapping(0, 255);
            2:       set_mapping(32767, 1);
            3:       set_mapping($urandom_range(0, 32767), $urandom_range(0, 32767));
            4:       set_mapping($urandom_range(0, 2000), $urandom_range(2, 20));
            default: set_mapping($urandom_range(0, 32767), 0);
         endcase
         // first phase runs with no idling on either side
         gaps_on   = (phase != 0);
         stalls_on = (phase != 0);
         for (n = 0; n < 100; n++) begin
            pad  = $urandom_range(0, 4095);
            trig = ($urandom_range(0, 99) < 30) ? $urandom_range(30, 35)
                                                 : $urandom_range(0, 255);
            send_snapshot(make_snapshot(pad, pick_axis(), pick_axis(), trig));
         end
      end
   endtask

   // receiver stall: mostly free, short holds, an occasional long one
   always @(posedge clock) begin : drive_rsp_stall
      int r;
      if (reset || !stalls_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_stall <= 1'b0;
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 50);
         end
      end
   end

   // compare each accepted frame with the oldest prediction
   always @(posedge clock) begin : check_frames
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_in_flight.size() == 0) begin
            $error("frame received with none outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = frames_in_flight.pop_front();
            frames_checked++;
            if (rsp_data.handheld_buttons !== want.handheld_buttons) begin
               $error("handheld_buttons mismatch: expected %h, actual %h",
                      want.handheld_buttons, rsp_data.handheld_buttons);
               mismatch_count++;
            end
            if (rsp_data.touch_x !== want.touch_x) begin
               $error("touch_x mismatch: expected %0d, actual %0d",
                      want.touch_x, rsp_data.touch_x);
               mismatch_count++;
            end
            if (rsp_data.touch_y !== want.touch_y) begin
               $error("touch_y mismatch: expected %0d, actual %0d",
                      want.touch_y, rsp_data.touch_y);
               mismatch_count++;
            end
            if (rsp_data.touch_pressed !== want.touch_pressed) begin
               $error("touch_pressed mismatch: expected %0d, actual %0d",
                      want.touch_pressed, rsp_data.touch_pressed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      deadband_now = int'(DZ_RESET);
      speed_now    = int'(SPEED_RESET);
      col_now      = SCREEN_WIDTH / 2;
      row_now      = SCREEN_HEIGHT / 2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_key_repack();
      test_deadband_edges();
      test_register_extremes();
      test_random_frames();

      // drain, then keep the clock running for stray frames
      wait_idle();
      repeat (48) @(posedge clock);

      $display("Sent %0d snapshots under %0d register settings, %0d frames compared.",
               snapshots_sent, settings_used, frames_checked);
      $display("Covered key repacking, dead zone borders, saturated registers and clamps.");
      if (mismatch_count == 0 && frames_in_flight.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
design/stcm_pkg.sv
design/stcm_front.sv
design/stcm_queue.sv
design/stcm_back.sv
design/stick_to_touch_cursor_mapper_core.sv
bench/tb_stick_to_touch_cursor_mapper_core.sv
